// ===== hdl/btt_pkg.sv =====
// ----------------------------------------------------------------------------
// btt_pkg
// Shared types and constants of the beacon tag tracker table.
// ----------------------------------------------------------------------------
package btt_pkg;

    localparam logic [1:0] KIND_HIT   = 2'd0;
    localparam logic [1:0] KIND_SWEEP = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    localparam logic [1:0] CFG_PROCESS_NOISE = 2'd0;
    localparam logic [1:0] CFG_MEAS_NOISE    = 2'd1;
    localparam logic [1:0] CFG_IDLE_TIMEOUT  = 2'd2;

    localparam logic [15:0] COV_ONE   = 16'd4096;
    localparam logic [7:0]  GAP_LIMIT = 8'd200;
    // sequence deltas 247..255 are backward skips of 1 to 9
    localparam logic [7:0]  BACK_MIN  = 8'd247;
    localparam logic [4:0]  DIV_STEPS = 5'd16;

    typedef enum logic [2:0] {
        ST_ADDED      = 3'd0,
        ST_REPEAT     = 3'd1,
        ST_UPDATED    = 3'd2,
        ST_BACKSKIP   = 3'd3,
        ST_FULL       = 3'd4,
        ST_SWEPT      = 3'd5,
        ST_READ_OK    = 3'd6,
        ST_READ_EMPTY = 3'd7
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_LOAD, S_EVAL, S_P1, S_DIV, S_MUL, S_COMMIT
    } state_t;

    typedef struct packed {
        logic        cap;
        logic        scan_en;
        logic        sel_hit;
        logic        rd_slot;
        logic        p1_en;
        logic        div_step;
        logic        mul_en;
        logic        commit;
        status_t     code;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       scan_done;
        logic       hit_found;
        logic       free_found;
        logic       read_ok;
        logic       seq_repeat;
        logic       seq_back;
        logic       div_done;
        logic       out_free;
    } sts_t;

    typedef struct packed {
        logic [15:0]        id;
        logic               cls;
        logic [7:0]         last_seq;
        logic [31:0]        last_seen;
        logic [31:0]        received;
        logic [31:0]        missed;
        logic signed [15:0] est;
        logic [15:0]        cov;
    } entry_t;

endpackage

// ===== hdl/btt_ctrl.sv =====
// ----------------------------------------------------------------------------
// btt_ctrl
// Sequencer: scan, slot load, filter division and commit of one transaction.
// ----------------------------------------------------------------------------
module btt_ctrl import btt_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic [1:0] s_tuser,
    output logic       s_tready,
    input  sts_t       sts,
    output cmd_t       cmd
);

    state_t  state_reg, state_next;
    status_t code_reg, code_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            code_reg  <= ST_FULL;
        end else begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        code_next  = code_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    case (s_tuser)
                        KIND_HIT, KIND_SWEEP: state_next = S_SCAN;
                        KIND_READ:            state_next = S_DECIDE;
                        default:              state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN: if (sts.scan_done) state_next = S_DECIDE;
            S_DECIDE: begin
                case (sts.kind)
                    KIND_HIT: begin
                        if (sts.hit_found) begin
                            state_next = S_LOAD;
                        end else begin
                            state_next = S_COMMIT;
                            code_next  = sts.free_found ? ST_ADDED : ST_FULL;
                        end
                    end
                    KIND_SWEEP: begin
                        state_next = S_COMMIT;
                        code_next  = ST_SWEPT;
                    end
                    default: begin
                        if (sts.read_ok) begin
                            state_next = S_LOAD;
                        end else begin
                            state_next = S_COMMIT;
                            code_next  = ST_READ_EMPTY;
                        end
                    end
                endcase
            end
            S_LOAD: state_next = S_EVAL;
            S_EVAL: begin
                if (sts.kind == KIND_READ) begin
                    state_next = S_COMMIT;
                    code_next  = ST_READ_OK;
                end else if (sts.seq_back) begin
                    state_next = S_COMMIT;
                    code_next  = ST_BACKSKIP;
                end else begin
                    state_next = S_P1;
                    code_next  = sts.seq_repeat ? ST_REPEAT : ST_UPDATED;
                end
            end
            S_P1:  state_next = S_DIV;
            S_DIV: if (sts.div_done) state_next = S_MUL;
            S_MUL: state_next = S_COMMIT;
            S_COMMIT: if (sts.out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        cmd.code = code_reg;
        s_tready = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:   cmd.cap      = s_tvalid;
            S_SCAN:   cmd.scan_en  = 1'b1;
            S_DECIDE: cmd.sel_hit  = (sts.kind == KIND_HIT);
            S_LOAD:   cmd.rd_slot  = 1'b1;
            S_P1:     cmd.p1_en    = 1'b1;
            S_DIV:    cmd.div_step = 1'b1;
            S_MUL:    cmd.mul_en   = 1'b1;
            S_COMMIT: cmd.commit   = sts.out_free;
            default:  cmd          = '0;
        endcase
    end

`ifndef SYNTHESIS
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> sts.out_free) else $error("commit with output busy");
    a_cap_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cap |-> state_reg == S_IDLE) else $error("capture outside idle");
    a_div_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV && sts.div_done) |=> state_reg == S_MUL)
        else $error("division end not followed by multiply");
`endif

endmodule

// ===== hdl/btt_datapath.sv =====
// ----------------------------------------------------------------------------
// btt_datapath
// Slot memory, valid bits, scan, Kalman filter arithmetic and result register.
// ----------------------------------------------------------------------------
module btt_datapath import btt_pkg::*; #(
    parameter int TAG_SLOTS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [71:0]   s_tdata,
    input  logic [1:0]    s_tuser,
    input  logic [15:0]   cfg_q,
    input  logic [15:0]   cfg_r,
    input  logic [31:0]   cfg_timeout,
    input  cmd_t          cmd,
    output sts_t          sts,
    input  logic          m_tready,
    output logic          m_tvalid,
    output logic [127:0]  m_tdata,
    output logic [2:0]    m_tuser
);

    localparam int IW = (TAG_SLOTS > 1) ? $clog2(TAG_SLOTS) : 1;
    localparam int CW = $clog2(TAG_SLOTS + 1);

    entry_t mem [TAG_SLOTS];
    entry_t rdata_reg;

    logic [TAG_SLOTS-1:0] act_reg, act_next;
    logic        fresh_reg, fresh_next;
    logic [1:0]  kind_reg;
    logic [15:0] tag_reg;
    logic        cls_reg;
    logic [7:0]  rssi_reg, seq_reg;
    logic [31:0] now_reg;
    logic [3:0]  idx_reg;

    logic [CW-1:0] cnt_reg, exp_reg;
    logic          chk_vld_reg;
    logic [IW-1:0] chk_idx_reg, sel_reg, hit_idx_reg, free_idx_reg;
    logic          found_reg, free_reg;

    logic [15:0] p1_reg;
    logic [16:0] den_reg, rem_reg;
    logic [15:0] quot_reg;
    logic [4:0]  dcnt_reg;
    logic signed [33:0] prod_e_reg;
    logic [32:0] prod_c_reg;

    logic         m_tvalid_reg;
    logic [127:0] m_tdata_reg;
    logic [2:0]   m_tuser_reg;

    logic          cnt_lt, rd_en, wr_en;
    logic [IW-1:0] raddr, waddr;
    logic          hit_chk, free_chk, exp_chk;
    logic [7:0]    diff8, gap8;
    logic [16:0]   p1_sum, rem2;
    logic [17:0]   rem_sh;
    logic [15:0]   p1_c, k_c;
    logic signed [15:0] z_c;
    logic signed [16:0] dz_c;
    entry_t        wdata, oent;
    logic          out_slot_flds;
    logic [3:0]    out_slot;
    logic [7:0]    out_gap, whole;
    logic          new_flag;

    assign cnt_lt   = cnt_reg < CW'(TAG_SLOTS);
    assign rd_en    = (cmd.scan_en && cnt_lt) || cmd.rd_slot;
    assign raddr    = cmd.scan_en ? cnt_reg[IW-1:0] : sel_reg;
    assign hit_chk  = chk_vld_reg && act_reg[chk_idx_reg] && rdata_reg.id == tag_reg;
    assign free_chk = chk_vld_reg && !act_reg[chk_idx_reg];
    assign exp_chk  = chk_vld_reg && act_reg[chk_idx_reg]
                    && (now_reg - rdata_reg.last_seen) > cfg_timeout;

    assign diff8 = seq_reg - rdata_reg.last_seq;
    assign gap8  = diff8 - 8'd1;
    assign z_c   = {rssi_reg, 8'h00};
    assign dz_c  = {z_c[15], z_c} - {rdata_reg.est[15], rdata_reg.est};

    assign p1_sum = {1'b0, rdata_reg.cov} + {1'b0, cfg_q};
    assign p1_c   = p1_sum[16] ? 16'hFFFF : p1_sum[15:0];
    assign rem_sh = {rem_reg, 1'b0};
    assign rem2   = (rem_sh >= {1'b0, den_reg}) ? 17'(rem_sh - {1'b0, den_reg})
                                                : rem_sh[16:0];
    // zero denominator gives no gain; zero r gives a gain of one, saturated
    assign k_c = (den_reg == 17'd0) ? 16'd0
               : (den_reg == {1'b0, p1_reg}) ? 16'hFFFF : quot_reg;

    always_comb begin
        sts            = '0;
        sts.kind       = kind_reg;
        sts.scan_done  = !cnt_lt && !chk_vld_reg;
        sts.hit_found  = found_reg;
        sts.free_found = free_reg;
        sts.read_ok    = ({5'd0, idx_reg} < 9'(TAG_SLOTS)) && act_reg[IW'(idx_reg)];
        sts.seq_repeat = (diff8 == 8'd0);
        sts.seq_back   = (diff8 >= BACK_MIN);
        sts.div_done   = (dcnt_reg == DIV_STEPS);
        sts.out_free   = !m_tvalid_reg || m_tready;
    end

    // new slot contents and the entry shown in the result
    always_comb begin
        wdata = rdata_reg;
        wr_en = 1'b0;
        waddr = sel_reg;
        out_gap = 8'd0;
        case (cmd.code)
            ST_ADDED: begin
                wdata.id        = tag_reg;
                wdata.cls       = cls_reg;
                wdata.last_seq  = seq_reg;
                wdata.last_seen = now_reg;
                wdata.received  = 32'd1;
                wdata.missed    = 32'd0;
                wdata.est       = z_c;
                wdata.cov       = COV_ONE;
                wr_en           = cmd.commit;
                waddr           = free_idx_reg;
            end
            ST_REPEAT, ST_UPDATED: begin
                wdata.est       = rdata_reg.est + prod_e_reg[31:16];
                wdata.cov       = prod_c_reg[31:16];
                wdata.last_seen = now_reg;
                wdata.received  = rdata_reg.received + 32'd1;
                if (cmd.code == ST_UPDATED) begin
                    wdata.last_seq = seq_reg;
                    if (gap8 < GAP_LIMIT) begin
                        wdata.missed = rdata_reg.missed + {24'd0, gap8};
                        out_gap      = gap8;
                    end
                end
                wr_en = cmd.commit;
            end
            default: wdata = rdata_reg;
        endcase
    end

    always_comb begin
        out_slot_flds = 1'b0;
        out_slot      = 4'd0;
        case (cmd.code)
            ST_ADDED: begin
                out_slot_flds = 1'b1;
                out_slot      = 4'(free_idx_reg);
            end
            ST_REPEAT, ST_UPDATED, ST_BACKSKIP, ST_READ_OK: begin
                out_slot_flds = 1'b1;
                out_slot      = 4'(sel_reg);
            end
            ST_READ_EMPTY: out_slot = idx_reg;
            default:       out_slot = 4'd0;
        endcase
        oent     = out_slot_flds ? wdata : '0;
        whole    = oent.est[15:8] + {7'd0, oent.est[15] & (|oent.est[7:0])};
        new_flag = (cmd.code == ST_ADDED || cmd.code == ST_UPDATED) ? 1'b1 : fresh_reg;
    end

    always_comb begin
        act_next   = act_reg;
        fresh_next = fresh_reg;
        if (cmd.cap && s_tuser == KIND_CLEAR) fresh_next = 1'b0;
        if (cmd.scan_en && kind_reg == KIND_SWEEP && exp_chk)
            act_next[chk_idx_reg] = 1'b0;
        if (cmd.commit) begin
            fresh_next = new_flag;
            if (cmd.code == ST_ADDED) act_next[free_idx_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg      <= '0;
            fresh_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            chk_vld_reg  <= 1'b0;
            cnt_reg      <= '0;
            kind_reg     <= KIND_HIT;
        end else begin
            act_reg   <= act_next;
            fresh_reg <= fresh_next;
            if (cmd.commit)    m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
            if (cmd.cap) begin
                kind_reg    <= s_tuser;
                cnt_reg     <= '0;
                chk_vld_reg <= 1'b0;
            end else if (cmd.scan_en) begin
                chk_vld_reg <= cnt_lt;
                if (cnt_lt) cnt_reg <= cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[waddr] <= wdata;
        if (rd_en) rdata_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            tag_reg   <= s_tdata[15:0];
            cls_reg   <= s_tdata[16];
            rssi_reg  <= s_tdata[24:17];
            seq_reg   <= s_tdata[32:25];
            now_reg   <= s_tdata[64:33];
            idx_reg   <= s_tdata[68:65];
            sel_reg   <= IW'(s_tdata[68:65]);
            found_reg <= 1'b0;
            free_reg  <= 1'b0;
            exp_reg   <= '0;
        end
        if (cmd.scan_en) begin
            chk_idx_reg <= cnt_reg[IW-1:0];
            if (hit_chk && !found_reg) begin
                found_reg   <= 1'b1;
                hit_idx_reg <= chk_idx_reg;
            end
            if (free_chk && !free_reg) begin
                free_reg     <= 1'b1;
                free_idx_reg <= chk_idx_reg;
            end
            if (kind_reg == KIND_SWEEP && exp_chk) exp_reg <= exp_reg + CW'(1);
        end
        if (cmd.sel_hit) sel_reg <= hit_idx_reg;
        if (cmd.p1_en) begin
            p1_reg   <= p1_c;
            den_reg  <= {1'b0, p1_c} + {1'b0, cfg_r};
            rem_reg  <= {1'b0, p1_c};
            quot_reg <= 16'd0;
            dcnt_reg <= 5'd0;
        end
        if (cmd.div_step && dcnt_reg != DIV_STEPS) begin
            rem_reg  <= rem2;
            quot_reg <= {quot_reg[14:0], rem_sh >= {1'b0, den_reg}};
            dcnt_reg <= dcnt_reg + 5'd1;
        end
        if (cmd.mul_en) begin
            prod_e_reg <= $signed({1'b0, k_c}) * dz_c;
            prod_c_reg <= (17'h10000 - {1'b0, k_c}) * p1_reg;
        end
        if (cmd.commit) begin
            m_tuser_reg <= cmd.code;
            m_tdata_reg <= {4'd0, new_flag,
                            (cmd.code == ST_SWEPT) ? 5'(exp_reg) : 5'd0,
                            oent.missed, oent.received, oent.id, oent.cls,
                            out_slot_flds, whole, oent.est, out_gap, out_slot};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_claim_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && cmd.code == ST_ADDED) |-> !act_reg[free_idx_reg])
        else $error("claim of an active slot");
    a_claim_sets: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && cmd.code == ST_ADDED) |=> fresh_reg && m_tvalid_reg)
        else $error("claim did not raise flag and result");
    a_clear_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.cap && s_tuser == KIND_CLEAR) |=> !fresh_reg)
        else $error("flag not cleared");
`endif

endmodule

// ===== hdl/beacon_tag_tracker_table_top.sv =====
// ----------------------------------------------------------------------------
// beacon_tag_tracker_table_top
// Per-tag tracker table with a fixed-point scalar Kalman filter on RSSI.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata hit fields, s_tuser kind
//  m_      | out | m_tvalid/m_tready  | m_tdata slot fields, m_tuser status
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_wdata
//
// One transaction at a time. A hit or sweep scans all TAG_SLOTS entries of the
// slot memory (one read port); a filtered hit then adds load, seq check, p1,
// the 16-step gain division and multiply, and a back-skip adds load and seq
// check. A read loads the slot and checks it (a free slot goes straight to
// commit); a flag clear only clears the flag. Reset clears the valid bits, the
// flag and the output; slot contents are written on claim. A result waiting
// on m_tready holds only the commit, not the next accept.
// ----------------------------------------------------------------------------
module beacon_tag_tracker_table_top import btt_pkg::*; #(
    parameter int TAG_SLOTS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tag_id[15:0] tag_class[16] rssi_dbm[24:17] seq_num[32:25]
    // now_ms[64:33] slot_index[68:65]
    input  logic [71:0]  s_tdata,
    input  logic [1:0]   s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    // slot[3:0] gap_added[11:4] rssi_estimate[27:12] rssi_whole[35:28]
    // slot_valid[36] slot_class[37] slot_tag_id[53:38] received_count[85:54]
    // missed_count[117:86] expired_count[122:118] new_data[123]
    output logic [127:0] m_tdata,
    output logic [2:0]   m_tuser,   // status
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);

    logic [15:0] q_reg, r_reg;
    logic [31:0] timeout_reg;
    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    // configuration registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg       <= 16'd410;
            r_reg       <= 16'd8192;
            timeout_reg <= 32'd10000;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_PROCESS_NOISE: q_reg       <= cfg_wdata[15:0];
                CFG_MEAS_NOISE:    r_reg       <= cfg_wdata[15:0];
                CFG_IDLE_TIMEOUT:  timeout_reg <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    btt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    btt_datapath #(.TAG_SLOTS(TAG_SLOTS)) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_q       (q_reg),
        .cfg_r       (r_reg),
        .cfg_timeout (timeout_reg),
        .cmd         (cmd),
        .sts         (sts),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule
